FILE: hdl/spisr_pkg.sv
// Shared types, codes and sizes of the SPI serial SRAM slave.
package spisr_pkg;

  // Both sizes must be powers of two.
  localparam int unsigned MemDepth  = 65536;
  localparam int unsigned PageBytes = 32;
  localparam int unsigned MemAw     = $clog2(MemDepth);
  localparam int unsigned PageW     = $clog2(PageBytes);

  localparam logic [7:0] CmdRead   = 8'h03;
  localparam logic [7:0] CmdWrite  = 8'h02;
  localparam logic [7:0] CmdRdMode = 8'h05;
  localparam logic [7:0] CmdWrMode = 8'h01;
  localparam logic [7:0] IdleByte  = 8'hFF;

  typedef enum logic [6:0] {
    PhIdle   = 7'b0000001,
    PhAddr   = 7'b0000010,
    PhRead   = 7'b0000100,
    PhWrite  = 7'b0001000,
    PhRdMode = 7'b0010000,
    PhWrMode = 7'b0100000,
    PhDone   = 7'b1000000
  } phase_e;

  typedef enum logic [1:0] {
    AmByte = 2'd0,
    AmSeq  = 2'd1,
    AmPage = 2'd2
  } access_e;

  typedef enum logic [1:0] {
    StOk   = 2'd0,
    StCmd  = 2'd1,
    StMode = 2'd2,
    StDone = 2'd3
  } status_e;

  typedef struct packed {
    logic             re;
    logic             we;
    logic [MemAw-1:0] addr;
    logic [7:0]       wdata;
  } mem_req_t;

  typedef struct packed {
    status_e    status;
    logic       from_ram;
    logic [7:0] miso;
  } result_t;

endpackage

FILE: hdl/spi_sram_slave.sv
// Top level of the SPI serial SRAM slave: decoder, SRAM and result register.
//
// Each input beat is one exchanged SPI byte or a chip-select release and
// yields exactly one result beat. One beat is taken per clock cycle; a result
// appears in the cycle after its input beat, held in a single output register
// (read data comes straight from the registered SRAM port). Input is taken
// whenever that register is empty or being emptied. The SRAM is one
// single-port memory of MemDepth bytes with a registered read; it is not
// cleared, so contents are undefined until written and no clearing pass runs
// after reset.
module spi_sram_slave (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] mosi_byte
  input  logic        s_axis_tuser_i,   // [0] cmd (1 = chip select released)
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o    // [7:0] miso_byte, [9:8] status, zero pad
);

  spisr_pkg::mem_req_t req;
  spisr_pkg::result_t  res;
  logic                beat;
  logic [7:0]          ram_rdata;

  logic               out_vld_q, out_vld_d;
  spisr_pkg::status_e status_q;
  logic               from_ram_q;
  logic [7:0]         miso_q;

  assign s_axis_tready_o = !out_vld_q || m_axis_tready_i;
  assign beat            = s_axis_tvalid_i && s_axis_tready_o;

  spisr_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .beat_i   (beat),
    .cs_rel_i (s_axis_tuser_i),
    .rx_i     (s_axis_tdata_i),
    .req_o    (req),
    .res_o    (res)
  );

  spisr_ram #(
    .Width (8),
    .Depth (spisr_pkg::MemDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .re_i    (req.re),
    .we_i    (req.we),
    .addr_i  (req.addr),
    .wdata_i (req.wdata),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    out_vld_d = out_vld_q;
    if (beat) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      from_ram_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
      if (beat) begin
        from_ram_q <= res.from_ram;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (beat) begin
      status_q <= res.status;
      miso_q   <= res.miso;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {6'd0, status_q, from_ram_q ? ram_rdata : miso_q};

  a_rd_to_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.re |=> out_vld_q && from_ram_q)
    else $error("read beat did not produce a RAM-sourced result");

  a_rw_excl : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(req.re && req.we))
    else $error("SRAM read and write issued together");

  a_rdata_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !m_axis_tready_i && from_ram_q |=> $stable(ram_rdata))
    else $error("read data changed under a stalled result");

  a_no_access_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !m_axis_tready_i |-> !req.re && !req.we)
    else $error("SRAM accessed while result stalled");

endmodule

FILE: hdl/spisr_ram.sv
// Generic single-port RAM with registered read.
module spisr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     re_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/spisr_ctrl.sv
// Command decoder and address sequencer: bus phase, mode and memory requests.
module spisr_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                beat_i,
  input  logic                cs_rel_i,
  input  logic [7:0]          rx_i,
  output spisr_pkg::mem_req_t req_o,
  output spisr_pkg::result_t  res_o
);

  spisr_pkg::phase_e  phase_q, phase_d;
  spisr_pkg::access_e mode_q, mode_d;
  logic               is_wr_q, is_wr_d;
  logic               hi_done_q, hi_done_d;
  logic [15:0]        addr_q, addr_d;
  logic [spisr_pkg::PageW-1:0] word_q, word_d;

  logic [15:0] full_addr;
  logic [15:0] lin_idx;

  assign full_addr = {addr_q[15:8], rx_i};
  assign lin_idx   = (mode_q == spisr_pkg::AmPage) ?
                     {addr_q[15:spisr_pkg::PageW], word_q} : addr_q;

  always_comb begin
    phase_d   = phase_q;
    mode_d    = mode_q;
    is_wr_d   = is_wr_q;
    hi_done_d = hi_done_q;
    addr_d    = addr_q;
    word_d    = word_q;

    req_o.re    = 1'b0;
    req_o.we    = 1'b0;
    req_o.addr  = lin_idx[spisr_pkg::MemAw-1:0];
    req_o.wdata = rx_i;

    res_o.status   = spisr_pkg::StOk;
    res_o.from_ram = 1'b0;
    res_o.miso     = spisr_pkg::IdleByte;

    if (cs_rel_i) begin
      phase_d = spisr_pkg::PhIdle;
    end else begin
      case (phase_q)
        spisr_pkg::PhIdle: begin
          if (rx_i == spisr_pkg::CmdRead || rx_i == spisr_pkg::CmdWrite) begin
            is_wr_d   = (rx_i == spisr_pkg::CmdWrite);
            hi_done_d = 1'b0;
            phase_d   = spisr_pkg::PhAddr;
          end else if (rx_i == spisr_pkg::CmdRdMode) begin
            phase_d = spisr_pkg::PhRdMode;
          end else if (rx_i == spisr_pkg::CmdWrMode) begin
            phase_d = spisr_pkg::PhWrMode;
          end else begin
            res_o.status = spisr_pkg::StCmd;
            phase_d      = spisr_pkg::PhDone;
          end
        end
        spisr_pkg::PhRdMode: begin
          res_o.miso = {mode_q, 6'b000000};
          phase_d    = spisr_pkg::PhDone;
        end
        spisr_pkg::PhWrMode: begin
          if (rx_i[5:0] != 6'd0 || rx_i[7:6] == 2'b11) begin
            res_o.status = spisr_pkg::StMode;
          end else begin
            mode_d = spisr_pkg::access_e'(rx_i[7:6]);
          end
          phase_d = spisr_pkg::PhDone;
        end
        spisr_pkg::PhAddr: begin
          if (!hi_done_q) begin
            addr_d    = {rx_i, 8'h00};
            hi_done_d = 1'b1;
          end else begin
            addr_d = full_addr;
            if (mode_q == spisr_pkg::AmPage) begin
              word_d = full_addr[spisr_pkg::PageW-1:0];
            end
            phase_d = is_wr_q ? spisr_pkg::PhWrite : spisr_pkg::PhRead;
          end
        end
        spisr_pkg::PhRead, spisr_pkg::PhWrite: begin
          if (phase_q == spisr_pkg::PhRead) begin
            req_o.re       = 1'b1;
            res_o.from_ram = 1'b1;
          end else begin
            req_o.we = 1'b1;
          end
          case (mode_q)
            spisr_pkg::AmByte: phase_d = spisr_pkg::PhDone;
            spisr_pkg::AmPage: word_d  = word_q + 1'b1;
            default:           addr_d  = addr_q + 16'd1;
          endcase
        end
        default: begin
          res_o.status = spisr_pkg::StDone;
          phase_d      = spisr_pkg::PhDone;
        end
      endcase
    end

    if (!beat_i) begin
      req_o.re = 1'b0;
      req_o.we = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= spisr_pkg::PhIdle;
      mode_q    <= spisr_pkg::AmSeq;
      is_wr_q   <= 1'b0;
      hi_done_q <= 1'b0;
      addr_q    <= 16'd0;
      word_q    <= '0;
    end else if (beat_i) begin
      phase_q   <= phase_d;
      mode_q    <= mode_d;
      is_wr_q   <= is_wr_d;
      hi_done_q <= hi_done_d;
      addr_q    <= addr_d;
      word_q    <= word_d;
    end
  end

endmodule

FILE: bench/tb_spi_sram_slave.sv
// Self-checking bench for the SPI serial SRAM slave: directed table, then random transactions.
module tb_spi_sram_slave;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] CmdDual  = 8'h3B;
  localparam logic [7:0] CmdReset = 8'hFF;
  localparam logic [7:0] ModeByte = 8'h00;
  localparam logic [7:0] ModeSeq  = 8'h40;
  localparam logic [7:0] ModePage = 8'h80;
  localparam logic [7:0] ModeBad  = 8'hC0;

  localparam int RandBeats  = 400;
  localparam int HoldCycles = 80;
  localparam int Limit      = 200000;

  typedef struct {
    logic [7:0]         miso;
    spisr_pkg::status_e st;
  } reply_t;

  typedef struct {
    logic               cs;
    logic [7:0]         b;
    bit                 known;
    logic [7:0]         miso;
    spisr_pkg::status_e st;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_tvalid;
  logic [7:0]  s_tdata;
  logic        s_tuser;
  logic        m_tready;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [15:0] m_axis_tdata_o;

  spi_sram_slave dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // predictor state
  spisr_pkg::phase_e            ph = spisr_pkg::PhIdle;
  logic                         pend_wr = 1'b0;
  logic                         hi_done = 1'b0;
  logic [15:0]                  addr = '0;
  logic [15-spisr_pkg::PageW:0] page = '0;
  logic [spisr_pkg::PageW-1:0]  word = '0;
  spisr_pkg::access_e           mode = spisr_pkg::AmSeq;
  logic [7:0]                   mem_img [spisr_pkg::MemDepth];
  bit                           written [spisr_pkg::MemDepth];
  logic [15:0]                  written_q [$];

  reply_t reply_q [$];
  int     errors = 0;
  int     cycles = 0;
  int     n_offered = 0;
  int     n_rd = 0, n_wr = 0, n_err = 0, n_mode = 0;
  int     burst_left = 0;
  bit     hold_req = 1'b0;

  row_t dir_tab [27] = '{
    '{1'b1, 8'hFF,                1'b1, spisr_pkg::IdleByte, spisr_pkg::StOk},
    '{1'b0, spisr_pkg::CmdRdMode, 1'b1, spisr_pkg::IdleByte, spisr_pkg::StOk},
    '{1'b0, 8'h00,                1'b1, ModeSeq,             spisr_pkg::StOk},
    '{1'b0, 8'hAA,                1'b1, spisr_pkg::IdleByte, spisr_pkg::StDone},
    '{1'b1, 8'h00,                1'b1, spisr_pkg::IdleByte, spisr_pkg::StOk},
    '{1'b0, spisr_pkg::CmdWrite,  1'b1, spisr_pkg::IdleByte, spisr_pkg::StOk},
    '{1'b0, 8'hFF,                1'b1, spisr_pkg::IdleByte, spisr_pkg::StOk},
    '{1'b0, 8'hFF,                1'b1, spisr_pkg::IdleByte, spisr_pkg::StOk},
    '{1'b0, 8'h00,                1'b1, spisr_pkg::IdleByte, spisr_pkg::StOk},
    '{1'b0, 8'hFF,                1'b1, spisr_pkg::IdleByte, spisr_pkg::StOk},
    '{1'b0, 8'h5A,                1'b1, spisr_pkg::IdleByte, spisr_pkg::StOk},
    '{1'b1, 8'hFF,                1'b1, spisr_pkg::IdleByte, spisr_pkg::StOk},
    '{1'b0, spisr_pkg::CmdRead,   1'b1, spisr_pkg::IdleByte, spisr_pkg::StOk},
    '{1'b0, 8'hFF,                1'b1, spisr_pkg::IdleByte, spisr_pkg::StOk},
    '{1'b0, 8'hFF,                1'b1, spisr_pkg::IdleByte, spisr_pkg::StOk},
    '{1'b0, 8'hFF,                1'b0, spisr_pkg::IdleByte, spisr_pkg::StOk},
    '{1'b0, 8'h00,                1'b0, spisr_pkg::IdleByte, spisr_pkg::StOk},
    '{1'b0, 8'hFF,                1'b0, spisr_pkg::IdleByte, spisr_pkg::StOk},
    '{1'b1, 8'h00,                1'b1, spisr_pkg::IdleByte, spisr_pkg::StOk},
    '{1'b0, spisr_pkg::CmdWrMode, 1'b1, spisr_pkg::IdleByte, spisr_pkg::StOk},
    '{1'b0, ModeBad,              1'b1, spisr_pkg::IdleByte, spisr_pkg::StMode},
    '{1'b0, 8'h01,                1'b1, spisr_pkg::IdleByte, spisr_pkg::StDone},
    '{1'b1, 8'hFF,                1'b1, spisr_pkg::IdleByte, spisr_pkg::StOk},
    '{1'b0, CmdDual,              1'b1, spisr_pkg::IdleByte, spisr_pkg::StCmd},
    '{1'b1, 8'hFF,                1'b1, spisr_pkg::IdleByte, spisr_pkg::StOk},
    '{1'b0, CmdReset,             1'b1, spisr_pkg::IdleByte, spisr_pkg::StCmd},
    '{1'b1, 8'h00,                1'b1, spisr_pkg::IdleByte, spisr_pkg::StOk}
  };

  function automatic logic [spisr_pkg::MemAw-1:0] mem_idx();
    logic [15:0] a;
    a = (mode == spisr_pkg::AmPage) ? {page, word} : addr;
    return a[spisr_pkg::MemAw-1:0];
  endfunction

  function automatic void step_addr();
    if (mode == spisr_pkg::AmByte) ph = spisr_pkg::PhDone;
    else if (mode == spisr_pkg::AmPage) word = word + 1'b1;
    else addr = addr + 16'd1;
  endfunction

  function automatic reply_t sram_predict(input logic cs, input logic [7:0] rx);
    reply_t                      r;
    logic [spisr_pkg::MemAw-1:0] i;
    r.miso = spisr_pkg::IdleByte;
    r.st   = spisr_pkg::StOk;
    if (cs) begin
      ph = spisr_pkg::PhIdle;
      return r;
    end
    case (ph)
      spisr_pkg::PhIdle: begin
        if (rx == spisr_pkg::CmdRead || rx == spisr_pkg::CmdWrite) begin
          pend_wr = (rx == spisr_pkg::CmdWrite);
          hi_done = 1'b0;
          ph = spisr_pkg::PhAddr;
        end else if (rx == spisr_pkg::CmdRdMode) begin
          ph = spisr_pkg::PhRdMode;
        end else if (rx == spisr_pkg::CmdWrMode) begin
          ph = spisr_pkg::PhWrMode;
        end else begin
          r.st = spisr_pkg::StCmd;
          ph = spisr_pkg::PhDone;
        end
      end
      spisr_pkg::PhRdMode: begin
        r.miso = {mode, 6'b0};
        ph = spisr_pkg::PhDone;
      end
      spisr_pkg::PhWrMode: begin
        if (rx[5:0] != 6'b0 || rx[7:6] == 2'b11) begin
          r.st = spisr_pkg::StMode;
        end else begin
          mode = spisr_pkg::access_e'(rx[7:6]);
          n_mode++;
        end
        ph = spisr_pkg::PhDone;
      end
      spisr_pkg::PhAddr: begin
        if (!hi_done) begin
          addr = {rx, 8'h00};
          hi_done = 1'b1;
        end else begin
          addr[7:0] = rx;
          if (mode == spisr_pkg::AmPage) {page, word} = addr;
          ph = pend_wr ? spisr_pkg::PhWrite : spisr_pkg::PhRead;
        end
      end
      spisr_pkg::PhRead: begin
        r.miso = mem_img[mem_idx()];
        n_rd++;
        step_addr();
      end
      spisr_pkg::PhWrite: begin
        i = mem_idx();
        mem_img[i] = rx;
        if (!written[i]) begin
          written[i] = 1'b1;
          written_q.push_back(16'(i));
        end
        n_wr++;
        step_addr();
      end
      default: begin
        r.st = spisr_pkg::StDone;
        ph = spisr_pkg::PhDone;
      end
    endcase
    if (r.st != spisr_pkg::StOk) n_err++;
    return r;
  endfunction

  task automatic report(input string msg);
    $display("mismatch at cycle %0d: %s", cycles, msg);
    errors++;
  endtask

  task automatic send_beat(input logic cs, input logic [7:0] b, input bit known,
                           input logic [7:0] k_miso, input spisr_pkg::status_e k_st);
    int     gap;
    reply_t r;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      @(negedge clk_i);
      s_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 16);
    end
    burst_left--;
    @(negedge clk_i);
    s_tvalid = 1'b1;
    s_tdata  = b;
    s_tuser  = cs;
    do @(posedge clk_i); while (!s_axis_tready_o);
    r = sram_predict(cs, b);
    if (known) begin
      r.miso = k_miso;
      r.st   = k_st;
    end
    reply_q.push_back(r);
  endtask

  // a data byte that would read a never-written cell becomes a chip-select release
  task automatic offer(input logic cs, input logic [7:0] b);
    if (!cs && ph == spisr_pkg::PhRead && !written[mem_idx()]) cs = 1'b1;
    n_offered++;
    send_beat(cs, b, 1'b0, spisr_pkg::IdleByte, spisr_pkg::StOk);
  endtask

  task automatic run_access(input bit wr);
    logic [15:0] a;
    int          n;
    int          sel;
    if (wr) begin
      sel = $urandom_range(0, 3);
      if (sel == 0) a = 16'hFFE0 | 16'($urandom_range(0, 31));
      else if (sel == 1) a = 16'h0100 | 16'($urandom_range(0, 255));
      else a = 16'($urandom);
    end else begin
      a = written_q[$urandom_range(0, written_q.size() - 1)];
    end
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 70) : $urandom_range(1, 12);
    offer(1'b0, wr ? spisr_pkg::CmdWrite : spisr_pkg::CmdRead);
    offer(1'b0, a[15:8]);
    offer(1'b0, a[7:0]);
    for (int k = 0; k < n; k++) begin
      if (ph == spisr_pkg::PhRead && !written[mem_idx()]) break;
      offer(1'b0, 8'($urandom));
    end
    if ($urandom_range(0, 9) != 0) offer(1'b1, 8'($urandom));
  endtask

  task automatic run_mode(input bit wr);
    int sel;
    offer(1'b0, wr ? spisr_pkg::CmdWrMode : spisr_pkg::CmdRdMode);
    sel = $urandom_range(0, 4);
    if (!wr || sel == 4) offer(1'b0, 8'($urandom));
    else if (sel == 0) offer(1'b0, ModeByte);
    else if (sel == 1) offer(1'b0, ModeSeq);
    else offer(1'b0, ModePage);
    if ($urandom_range(0, 2) == 0) offer(1'b0, 8'($urandom));
    offer(1'b1, 8'($urandom));
  endtask

  task automatic run_noise();
    int k;
    repeat ($urandom_range(1, 4)) begin
      k = $urandom_range(0, 4);
      if (k == 0) offer(1'b1, 8'($urandom));
      else if (k == 1) offer(1'b0, $urandom_range(0, 1) ? CmdDual : CmdReset);
      else offer(1'b0, 8'($urandom));
    end
  endtask

  // result side: stall pattern plus one long hold-off on request
  initial begin
    int hold_left;
    int seg_left;
    int style;
    hold_left = 0;
    seg_left  = 0;
    style     = 0;
    m_tready  = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        m_tready = 1'b0;
        hold_left--;
      end else begin
        if (seg_left == 0) begin
          style    = $urandom_range(0, 3);
          seg_left = $urandom_range(8, 60);
        end
        seg_left--;
        case (style)
          0:       m_tready = 1'b1;
          1:       m_tready = ($urandom_range(0, 3) != 0);
          2:       m_tready = ($urandom_range(0, 2) == 0);
          default: m_tready = $urandom_range(0, 1);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    reply_t e;
    if (rst_ni && m_axis_tvalid_o && m_tready) begin
      if (reply_q.size() == 0) begin
        report($sformatf("unexpected beat %h", m_axis_tdata_o));
      end else begin
        e = reply_q.pop_front();
        if (m_axis_tdata_o[7:0] !== e.miso)
          report($sformatf("miso %h, want %h", m_axis_tdata_o[7:0], e.miso));
        if (m_axis_tdata_o[9:8] !== e.st)
          report($sformatf("status %0d, want %0d", m_axis_tdata_o[9:8], e.st));
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= Limit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    bit held;
    bit drained;
    int pick;
    held     = 1'b0;
    drained  = 1'b0;
    rst_ni   = 1'b0;
    s_tvalid = 1'b0;
    s_tdata  = 8'h00;
    s_tuser  = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_tab[i])
      send_beat(dir_tab[i].cs, dir_tab[i].b, dir_tab[i].known, dir_tab[i].miso, dir_tab[i].st);

    @(negedge clk_i);
    s_tvalid = 1'b0;
    while (reply_q.size() != 0) @(posedge clk_i);

    while (n_offered < RandBeats) begin
      if (!held && n_offered >= 120) begin
        held       = 1'b1;
        hold_req   = 1'b1;
        burst_left = 200;
      end
      if (!drained && n_offered >= 260) begin
        drained = 1'b1;
        @(negedge clk_i);
        s_tvalid = 1'b0;
        while (reply_q.size() != 0) @(posedge clk_i);
      end
      pick = $urandom_range(0, 99);
      if (pick < 30 || written_q.size() == 0) run_access(1'b1);
      else if (pick < 58) run_access(1'b0);
      else if (pick < 70) run_mode(1'b1);
      else if (pick < 78) run_mode(1'b0);
      else run_noise();
    end

    @(negedge clk_i);
    s_tvalid = 1'b0;
    while (reply_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Run: %0d random beats after the table, %0d data writes, %0d data reads,",
             n_offered, n_wr, n_rd);
    $display("     %0d error replies, %0d mode changes, %0d cells written",
             n_err, n_mode, written_q.size());
    if (errors == 0 && reply_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: spi_sram_slave.f
hdl/spisr_pkg.sv
hdl/spisr_ram.sv
hdl/spisr_ctrl.sv
hdl/spi_sram_slave.sv
bench/tb_spi_sram_slave.sv
